[hw/rtl/signed_binary_to_ascii_decimal_defines.svh]
// Assertion macros for the signed binary to ASCII decimal converter.
// Each macro uses the clk and rst_n signals of the module that includes this file.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH
`define SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define SB2DEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sb2dec: same-cycle check failed");
// Next-cycle implication, checked outside reset
`define SB2DEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sb2dec: next-cycle check failed");
`else
`define SB2DEC_ASSERT_SAME(label, ante, cons)
`define SB2DEC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/sb2dec_pkg.sv]
// Shared constants for the signed binary to ASCII decimal converter.
// Depends on nothing; used by the top level signed_binary_to_ascii_decimal.
package sb2dec_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int NIB_W   = 4;

  // Default size of the BCD digit buffer
  localparam int MAX_DIGITS_DEF = 10;

  // Conversion step counter covers one step per magnitude bit
  localparam int CNT_W = $clog2(VALUE_W);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // BCD digit correction threshold and offset for shift-add-3
  localparam logic [NIB_W-1:0] BCD_FIX_MIN = 4'd5;
  localparam logic [NIB_W-1:0] BCD_FIX_ADD = 4'd3;

endpackage

[hw/rtl/signed_binary_to_ascii_decimal.sv]
// Signed 32-bit integer to decimal ASCII text, one character per output request.
// Flow: 32 shift-add-3 steps on the shared BCD unit, a digit-count step (ST_PREP), then
// the characters are loaded into the output register, 1/cycle while the sink is ready.
// A new number is accepted only after the last of the previous N = 1..11 chars is loaded.
// Reset: synchronous, active low; clears control and valid state, no clearing pass.
// Depends on sb2dec_pkg and signed_binary_to_ascii_decimal_defines.svh.
`include "signed_binary_to_ascii_decimal_defines.svh"

module signed_binary_to_ascii_decimal #(
  parameter int MAX_DIGITS = sb2dec_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input request
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sb2dec_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value (signed)
  // result request
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sb2dec_pkg::CHAR_W-1:0]  out_tdata,  // [7:0] character
  output logic                           out_tlast
);

  localparam int BCD_W = sb2dec_pkg::NIB_W * MAX_DIGITS;
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int VW    = sb2dec_pkg::VALUE_W;
  localparam int CW    = sb2dec_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [VW-1:0]                   bin_r, bin_nxt;
  logic [BCD_W-1:0]                bcd_r, bcd_nxt;
  logic                            neg_r, neg_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [sb2dec_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [BCD_W-1:0]                bcd_adj;
  logic [IDX_W-1:0]                top_idx;
  logic [VW-1:0]                   in_mag;
  logic [sb2dec_pkg::NIB_W-1:0]    cur_digit;
  logic                            out_free;
  logic                            in_acc;
  logic                            out_is_minus;
  logic                            out_char_ok;

  // Shared unit: add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W] >= sb2dec_pkg::BCD_FIX_MIN) begin
        bcd_adj[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W] =
          bcd_r[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W] + sb2dec_pkg::BCD_FIX_ADD;
      end else begin
        bcd_adj[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W] =
          bcd_r[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W];
      end
    end
  end

  // Find the highest nonzero digit; zero keeps a single digit
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd_r[i*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // Unsigned magnitude, so the most negative value converts as well
  assign in_mag    = in_tdata[VW-1] ? (VW'(0) - in_tdata) : in_tdata;
  assign cur_digit = bcd_r[idx_r*sb2dec_pkg::NIB_W +: sb2dec_pkg::NIB_W];
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    neg_nxt        = neg_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;

    // drop the held character once it is taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          neg_nxt   = in_tdata[VW-1];
          bin_nxt   = in_mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // one shift-add-3 step per magnitude bit, MSB first
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VW-1]};
        bin_nxt = {bin_r[VW-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(VW - 1)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        idx_nxt   = top_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // load the next character whenever the output slot is free
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = sb2dec_pkg::CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = sb2dec_pkg::CHAR_ZERO +
                           {{(sb2dec_pkg::CHAR_W - sb2dec_pkg::NIB_W){1'b0}}, cur_digit};
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      neg_r        <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      neg_r        <= neg_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // Classify the character on the output for the checks below
  assign out_is_minus = (out_tdata == sb2dec_pkg::CHAR_MINUS);
  assign out_char_ok  = out_is_minus ||
                        ((out_tdata >= sb2dec_pkg::CHAR_ZERO) &&
                         (out_tdata <= sb2dec_pkg::CHAR_NINE));

  // Block stays busy for the conversion after taking a number
  `SB2DEC_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  // A minus sign never ends the text
  `SB2DEC_ASSERT_SAME(a_minus_not_last, out_tvalid && out_is_minus, !out_tlast)
  // Only a sign or a decimal digit leaves the block
  `SB2DEC_ASSERT_SAME(a_char_legal, out_tvalid, out_char_ok)

endmodule
